@@ rtl/clsc_pkg.sv @@
// Shared types, codes and frequency tables for the clock level step controller.
// Depends on nothing; used by the top level and its checker.
package clsc_pkg;

  localparam int unsigned FREQ_W     = 10;
  localparam int unsigned TABLE_ROWS = 4;
  localparam int unsigned ROM_WIDTH  = 16;

  localparam logic [2:0] CMD_STEP_TARGET   = 3'd0;
  localparam logic [2:0] CMD_STEP_MAX      = 3'd1;
  localparam logic [2:0] CMD_SET_MODE      = 3'd2;
  localparam logic [2:0] CMD_STEP_PLAN     = 3'd3;
  localparam logic [2:0] CMD_LOAD_MEASURED = 3'd4;
  localparam logic [2:0] CMD_CLEAR_CHANGED = 3'd5;

  localparam logic [1:0] MODE_DEFAULT  = 2'd0;
  localparam logic [1:0] MODE_AUTO     = 2'd1;
  localparam logic [1:0] MODE_MANUAL   = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [0:0] ADDR_AUTO_MIN = 1'b0;

  localparam logic [FREQ_W-1:0] AUTO_MIN_RESET = 10'd41;

  typedef logic [FREQ_W-1:0] freq_t;

  // Ascending frequency tables, one row per domain; unused slots are zero.
  localparam freq_t FREQ_ROM [TABLE_ROWS][ROM_WIDTH] = '{
    '{10'd41, 10'd83, 10'd111, 10'd126, 10'd147, 10'd166, 10'd181, 10'd209,
      10'd222, 10'd251, 10'd292, 10'd333, 10'd389, 10'd444, 10'd468, 10'd500},
    '{10'd41, 10'd55, 10'd83, 10'd111, 10'd166, 10'd222, 10'd0, 10'd0,
      10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd55, 10'd83, 10'd111, 10'd166, 10'd222, 10'd0, 10'd0, 10'd0,
      10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd83, 10'd111, 10'd166, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
      10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0}
  };

  localparam logic [4:0] ROM_COUNT [TABLE_ROWS] = '{5'd16, 5'd6, 5'd5, 5'd3};

  localparam freq_t ROM_DEFAULT [TABLE_ROWS] = '{10'd333, 10'd111, 10'd222, 10'd111};

  // Next table entry above (up) or below the current value; the current value
  // when there is none. Only the first lim entries of the row take part.
  function automatic freq_t step_level(input logic [1:0] d, input freq_t cur,
                                       input logic up, input logic [5:0] lim);
    freq_t res;
    logic  found;
    logic  use_entry;
    res   = cur;
    found = 1'b0;
    for (int i = 0; i < ROM_WIDTH; i++) begin
      use_entry = (i < ROM_COUNT[d]) && (i < lim);
      if (use_entry && up && !found && (FREQ_ROM[d][i] > cur)) begin
        res   = FREQ_ROM[d][i];
        found = 1'b1;
      end
      if (use_entry && !up && (FREQ_ROM[d][i] < cur)) begin
        res = FREQ_ROM[d][i];
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/clock_level_step_controller.sv @@
// Clock level step controller for up to four clock domains.
// Depends on clsc_pkg for the command and mode codes and the frequency tables.

// One command is taken in every cycle while the result side keeps up; each
// request passes an input register and then a result register, which offers
// its result. Domain state (mode, target, maximum, plan) and the shared
// changed flag are updated in the cycle the request leaves the input register,
// so back-to-back requests to the same domain see each other's effect. The
// table step is a parallel compare across the domain's row. auto_min_freq sits
// at byte address 0 of the register port.
module clock_level_step_controller #(
  parameter int unsigned DOMAINS     = 4,
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned PLAN_LEVELS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] device, [2] raise, [4:3] new_mode, [14:5] measured_freq, [15] zero
  input  logic [15:0] s_axis_tdata_i,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [9:0] apply_freq, [19:10] target_out, [29:20] max_out, [31:30] mode_out,
  // [33:32] plan_out, [34] changed, [39:35] zero
  output logic [39:0] m_axis_tdata_o,
  // [0] apply_valid
  output logic [0:0]  m_axis_tuser_o,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W   = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
  localparam int unsigned PLAN_W  = 2;
  localparam logic [5:0]  LIM     = 6'(TABLE_DEPTH);
  localparam logic [PLAN_W-1:0] PLAN_TOP = PLAN_W'(PLAN_LEVELS - 1);

  typedef logic [clsc_pkg::FREQ_W-1:0] freq_t;

  // Register port.
  clsc_pkg::freq_t auto_min_q;

  assign pready = 1'b1;
  assign prdata = (paddr == clsc_pkg::ADDR_AUTO_MIN) ? {22'd0, auto_min_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_min_q <= clsc_pkg::AUTO_MIN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == clsc_pkg::ADDR_AUTO_MIN)) begin
      auto_min_q <= pwdata[clsc_pkg::FREQ_W-1:0];
    end
  end

  // Input register.
  logic        in_valid_q;
  logic [2:0]  cmd_q;
  logic [1:0]  dev_q;
  logic        raise_q;
  logic [1:0]  new_mode_q;
  freq_t       meas_q;
  logic        advance;
  logic        out_valid_q;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q      <= s_axis_tuser_i;
      dev_q      <= s_axis_tdata_i[1:0];
      raise_q    <= s_axis_tdata_i[2];
      new_mode_q <= s_axis_tdata_i[4:3];
      meas_q     <= s_axis_tdata_i[14:5];
    end
  end

  // Domain state.
  logic [1:0]        mode_q   [DOMAINS];
  freq_t             target_q [DOMAINS];
  freq_t             max_q    [DOMAINS];
  logic [PLAN_W-1:0] plan_q   [DOMAINS];
  logic              changed_q;

  logic [2:0]        dev_ext;
  logic [IDX_W-1:0]  idx;
  logic              present;
  logic [1:0]        mode_cur;
  freq_t             tgt_cur, max_cur;
  logic [PLAN_W-1:0] plan_cur;

  assign dev_ext  = {1'b0, dev_q};
  assign idx      = dev_ext[IDX_W-1:0];
  assign present  = (32'(dev_q) < DOMAINS);
  assign mode_cur = mode_q[idx];
  assign tgt_cur  = target_q[idx];
  assign max_cur  = max_q[idx];
  assign plan_cur = plan_q[idx];

  logic [1:0]        mode_d;
  freq_t             tgt_d, max_d;
  logic [PLAN_W-1:0] plan_d;
  logic              changed_d;
  logic              apply_d;
  freq_t             afreq_d;
  freq_t             step_t, step_m;

  always_comb begin
    mode_d    = mode_cur;
    tgt_d     = tgt_cur;
    max_d     = max_cur;
    plan_d    = plan_cur;
    changed_d = changed_q;
    apply_d   = 1'b0;
    afreq_d   = '0;
    step_t    = clsc_pkg::step_level(dev_q, tgt_cur, raise_q, LIM);
    step_m    = clsc_pkg::step_level(dev_q, max_cur, raise_q, LIM);
    case (cmd_q)
      clsc_pkg::CMD_STEP_TARGET: begin
        // In auto mode the maximum wins over the auto floor.
        if (mode_cur == clsc_pkg::MODE_AUTO) begin
          if (step_t < auto_min_q) step_t = auto_min_q;
          if (step_t > max_cur) step_t = max_cur;
        end
        if (mode_cur == clsc_pkg::MODE_MANUAL) begin
          max_d     = step_t;
          changed_d = 1'b1;
        end
        tgt_d = step_t;
        if (mode_cur != clsc_pkg::MODE_DEFAULT) begin
          apply_d = 1'b1;
          afreq_d = max_d;
        end
      end
      clsc_pkg::CMD_STEP_MAX: begin
        max_d     = step_m;
        changed_d = 1'b1;
        if (tgt_cur > step_m) begin
          tgt_d   = step_m;
          apply_d = 1'b1;
          if (mode_cur == clsc_pkg::MODE_MANUAL || mode_cur == clsc_pkg::MODE_AUTO) begin
            afreq_d = step_m;
          end else begin
            afreq_d = clsc_pkg::ROM_DEFAULT[dev_q];
          end
        end
      end
      clsc_pkg::CMD_SET_MODE: begin
        if (new_mode_q != clsc_pkg::MODE_RESERVED) begin
          mode_d    = new_mode_q;
          changed_d = 1'b1;
          apply_d   = 1'b1;
          case (new_mode_q)
            clsc_pkg::MODE_MANUAL: afreq_d = max_cur;
            clsc_pkg::MODE_AUTO:   afreq_d = tgt_cur;
            default:               afreq_d = clsc_pkg::ROM_DEFAULT[dev_q];
          endcase
        end
      end
      clsc_pkg::CMD_STEP_PLAN: begin
        if (raise_q && (plan_cur < PLAN_TOP)) begin
          plan_d    = plan_cur + 1'b1;
          changed_d = 1'b1;
        end else if (!raise_q && (plan_cur != '0)) begin
          plan_d    = plan_cur - 1'b1;
          changed_d = 1'b1;
        end
      end
      clsc_pkg::CMD_LOAD_MEASURED: begin
        tgt_d     = meas_q;
        max_d     = meas_q;
        changed_d = 1'b1;
      end
      clsc_pkg::CMD_CLEAR_CHANGED: begin
        changed_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  logic do_update;
  assign do_update = in_valid_q && advance && present;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DOMAINS; i++) begin
        mode_q[i]   <= clsc_pkg::MODE_DEFAULT;
        target_q[i] <= '0;
        max_q[i]    <= '0;
        plan_q[i]   <= '0;
      end
      changed_q <= 1'b1;
    end else if (do_update) begin
      mode_q[idx]   <= mode_d;
      target_q[idx] <= tgt_d;
      max_q[idx]    <= max_d;
      plan_q[idx]   <= plan_d;
      changed_q     <= changed_d;
    end
  end

  // Result register.
  logic [39:0] out_data_q;
  logic        out_apply_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      if (present) begin
        out_apply_q <= apply_d;
        out_data_q  <= {5'd0, changed_d, plan_d, mode_d, max_d, tgt_d, afreq_d};
      end else begin
        out_apply_q <= 1'b0;
        out_data_q  <= {5'd0, changed_q, 34'd0};
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_apply_q;

endmodule

@@ rtl/clsc_checker.sv @@
// Port-level checks for the clock level step controller, bound to the top level.
// Depends on clsc_pkg for the mode codes.
module clsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // No frequency is reported unless one is to be applied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[9:0] == '0)
    else $error("apply_freq set without apply_valid");

  // The unused mode code is never stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[31:30] != clsc_pkg::MODE_RESERVED)
    else $error("mode_out holds the unused code");

  // In manual mode the applied frequency is always the domain maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] &&
      (m_axis_tdata_o[31:30] == clsc_pkg::MODE_MANUAL) |->
      m_axis_tdata_o[9:0] == m_axis_tdata_o[29:20])
    else $error("manual mode applied a frequency other than the maximum");

endmodule

bind clock_level_step_controller clsc_checker u_clsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

@@ tb/clsc_tb_pkg.sv @@
// Request and result types plus the result scoreboard for the clock level step controller.
// Depends on clsc_pkg for the command and mode codes and the frequency tables.
`timescale 1ns / 1ps
package clsc_tb_pkg;
  import clsc_pkg::*;

  localparam int unsigned DOMAIN_COUNT = 4;
  localparam logic [1:0]  PLAN_SAVER = 2'd0;
  localparam logic [1:0]  PLAN_TOP = 2'd2;
  localparam logic [2:0]  CMD_SPARE_A = 3'd6;
  localparam logic [2:0]  CMD_SPARE_B = 3'd7;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [0:0]  AUTO_MIN_ADDR = 1'b0;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] dev;
    logic       raise;
    logic [1:0] mode_sel;
    freq_t      measured;
  } level_cmd_t;

  typedef struct packed {
    logic       apply_valid;
    freq_t      apply_freq;
    freq_t      target;
    freq_t      ceiling;
    logic [1:0] mode;
    logic [1:0] plan;
    logic       changed;
  } level_result_t;

  class clock_level_scoreboard;
    freq_t         auto_floor;
    logic [1:0]    level_mode[DOMAIN_COUNT];
    freq_t         level_target[DOMAIN_COUNT];
    freq_t         level_ceiling[DOMAIN_COUNT];
    logic [1:0]    level_plan[DOMAIN_COUNT];
    logic          profile_dirty;
    level_result_t pending[$];
    int            errors;
    int            checked;
    int            applied;
    int            cmd_seen[8];

    function new();
      auto_floor = AUTO_MIN_RESET;
      for (int d = 0; d < DOMAIN_COUNT; d++) begin
        level_mode[d] = MODE_DEFAULT;
        level_target[d] = '0;
        level_ceiling[d] = '0;
        level_plan[d] = PLAN_SAVER;
      end
      profile_dirty = 1'b1;
      errors = 0;
      checked = 0;
      applied = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    // Nearest row entry above or below cur; cur itself when the row has none.
    function freq_t next_level(int d, freq_t cur, logic up);
      int n;
      n = ROM_COUNT[d];
      if (up) begin
        for (int i = 0; i < n; i++)
          if (FREQ_ROM[d][i] > cur) return FREQ_ROM[d][i];
      end else begin
        for (int i = n - 1; i >= 0; i--)
          if (FREQ_ROM[d][i] < cur) return FREQ_ROM[d][i];
      end
      return cur;
    endfunction

    function freq_t mode_freq(int d);
      if (level_mode[d] == MODE_MANUAL) return level_ceiling[d];
      if (level_mode[d] == MODE_AUTO) return level_target[d];
      return ROM_DEFAULT[d];
    endfunction

    function void note_request(level_cmd_t r);
      level_result_t e;
      int            d;
      freq_t         t;
      d = r.dev;
      e = '0;
      cmd_seen[r.cmd]++;
      case (r.cmd)
        CMD_STEP_TARGET: begin
          t = next_level(d, level_target[d], r.raise);
          if (level_mode[d] == MODE_AUTO) begin
            if (t < auto_floor) t = auto_floor;
            if (t > level_ceiling[d]) t = level_ceiling[d];
          end
          if (level_mode[d] == MODE_MANUAL) begin
            level_ceiling[d] = t;
            profile_dirty = 1'b1;
          end
          level_target[d] = t;
          if (level_mode[d] != MODE_DEFAULT) begin
            e.apply_valid = 1'b1;
            e.apply_freq = level_ceiling[d];
          end
        end
        CMD_STEP_MAX: begin
          level_ceiling[d] = next_level(d, level_ceiling[d], r.raise);
          if (level_target[d] > level_ceiling[d]) begin
            level_target[d] = level_ceiling[d];
            e.apply_valid = 1'b1;
            e.apply_freq = mode_freq(d);
          end
          profile_dirty = 1'b1;
        end
        CMD_SET_MODE: begin
          if (r.mode_sel != MODE_UNUSED) begin
            level_mode[d] = r.mode_sel;
            profile_dirty = 1'b1;
            e.apply_valid = 1'b1;
            e.apply_freq = mode_freq(d);
          end
        end
        CMD_STEP_PLAN: begin
          if (r.raise && level_plan[d] < PLAN_TOP) begin
            level_plan[d]++;
            profile_dirty = 1'b1;
          end else if (!r.raise && level_plan[d] > PLAN_SAVER) begin
            level_plan[d]--;
            profile_dirty = 1'b1;
          end
        end
        CMD_LOAD_MEASURED: begin
          level_target[d] = r.measured;
          level_ceiling[d] = r.measured;
          profile_dirty = 1'b1;
        end
        CMD_CLEAR_CHANGED: profile_dirty = 1'b0;
        default: ;
      endcase
      e.target = level_target[d];
      e.ceiling = level_ceiling[d];
      e.mode = level_mode[d];
      e.plan = level_plan[d];
      e.changed = profile_dirty;
      if (e.apply_valid) applied++;
      pending.push_back(e);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(level_result_t got);
      level_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no request outstanding, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("apply_valid", want.apply_valid, got.apply_valid);
      compare_field("apply_freq", want.apply_freq, got.apply_freq);
      compare_field("target_out", want.target, got.target);
      compare_field("max_out", want.ceiling, got.ceiling);
      compare_field("mode_out", want.mode, got.mode);
      compare_field("plan_out", want.plan, got.plan);
      compare_field("changed", want.changed, got.changed);
    endfunction
  endclass

endpackage

@@ tb/testbench.sv @@
// Top-level testbench: drives commands and register writes into the clock level step
// controller and checks every result. Depends on clsc_pkg and clsc_tb_pkg.
`timescale 1ns / 1ps
module testbench;
  import clsc_pkg::*;
  import clsc_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 316;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clock_level_scoreboard sb;
  rx_style_e             rx_style = RX_OPEN;
  int                    style_left = 0;
  logic [7:0]            rx_cycle = '0;
  int                    quiet_cycles = 0;
  int                    floor_settings = 1;

  clock_level_step_controller DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: check, watchdog and the receiver's own stall pattern.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result({m_axis_tuser_o[0], m_axis_tdata_o[9:0], m_axis_tdata_o[19:10],
                         m_axis_tdata_o[29:20], m_axis_tdata_o[31:30],
                         m_axis_tdata_o[33:32], m_axis_tdata_o[34]});
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
    if (style_left == 0) begin
      rx_style <= rx_style_e'($urandom_range(0, 3));
      style_left <= $urandom_range(16, 96);
    end else begin
      style_left <= style_left - 1;
    end
    case (rx_style)
      RX_OPEN: m_axis_tready_i <= 1'b1;
      RX_COIN: m_axis_tready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= (rx_cycle[2:0] < 3'd3);
    endcase
    rx_cycle <= rx_cycle + 1'b1;
  end

  // Holds the request until the block takes it; tvalid stays high on return.
  task automatic send(logic [2:0] cmd, logic [1:0] dev, logic raise, logic [1:0] mode_sel,
                      freq_t measured);
    level_cmd_t r;
    r = '{cmd: cmd, dev: dev, raise: raise, mode_sel: mode_sel, measured: measured};
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {1'b0, measured, mode_sel, raise, dev};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(r);
  endtask

  task automatic pause_sender(int cycles);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    pause_sender(0);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_auto_floor(freq_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AUTO_MIN_ADDR;
    pwdata <= {22'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.auto_floor = value;
  endtask

  function automatic freq_t pick_measured(logic [1:0] dev);
    int f;
    f = FREQ_ROM[dev][$urandom_range(0, ROM_COUNT[dev] - 1)];
    case ($urandom_range(0, 3))
      0: f = f + 1;
      1: f = f - 1;
      2: f = $urandom_range(0, 1023);
      default: ;
    endcase
    if (f < 0) f = 0;
    if (f > 1023) f = 1023;
    return freq_t'(f);
  endfunction

  task automatic send_random();
    int         w;
    logic [2:0] cmd;
    logic [1:0] dev;
    logic [1:0] mode_sel;
    w = $urandom_range(0, 99);
    dev = 2'($urandom_range(0, 3));
    if (w < 30) cmd = CMD_STEP_TARGET;
    else if (w < 50) cmd = CMD_STEP_MAX;
    else if (w < 63) cmd = CMD_SET_MODE;
    else if (w < 74) cmd = CMD_STEP_PLAN;
    else if (w < 88) cmd = CMD_LOAD_MEASURED;
    else if (w < 96) cmd = CMD_CLEAR_CHANGED;
    else if (w < 98) cmd = CMD_SPARE_A;
    else cmd = CMD_SPARE_B;
    mode_sel = ($urandom_range(0, 19) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
    send(cmd, dev, 1'($urandom_range(0, 1)), mode_sel, pick_measured(dev));
  endtask

  task automatic run_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_random();
        sent++;
      end
      if ($urandom_range(0, 24) == 0) drain();
      else if ($urandom_range(0, 9) >= 3) pause_sender($urandom_range(1, 12));
    end
  endtask

  task automatic run_directed();
    send(CMD_STEP_TARGET, 2'd0, 1'b1, MODE_DEFAULT, 10'd0);
    send(CMD_STEP_TARGET, 2'd0, 1'b0, MODE_DEFAULT, 10'd0);
    send(CMD_LOAD_MEASURED, 2'd1, 1'b0, MODE_DEFAULT, 10'h3FF);
    send(CMD_STEP_MAX, 2'd1, 1'b1, MODE_DEFAULT, 10'd0);
    // Maximum drops below the target, so the target is pulled down with it.
    send(CMD_STEP_MAX, 2'd1, 1'b0, MODE_DEFAULT, 10'd0);
    send(CMD_SET_MODE, 2'd2, 1'b0, MODE_AUTO, 10'd0);
    send(CMD_STEP_TARGET, 2'd2, 1'b1, MODE_DEFAULT, 10'd0);
    send(CMD_LOAD_MEASURED, 2'd2, 1'b1, MODE_MANUAL, 10'h2AA);
    send(CMD_STEP_TARGET, 2'd2, 1'b0, MODE_DEFAULT, 10'd0);
    send(CMD_STEP_MAX, 2'd2, 1'b0, MODE_DEFAULT, 10'd0);
    send(CMD_SET_MODE, 2'd3, 1'b1, MODE_MANUAL, 10'h155);
    send(CMD_STEP_TARGET, 2'd3, 1'b1, MODE_DEFAULT, 10'd0);
    send(CMD_STEP_TARGET, 2'd3, 1'b1, MODE_DEFAULT, 10'd0);
    send(CMD_STEP_MAX, 2'd3, 1'b0, MODE_DEFAULT, 10'd0);
    send(CMD_SET_MODE, 2'd0, 1'b0, MODE_UNUSED, 10'd0);
    send(CMD_SPARE_A, 2'd1, 1'b1, MODE_UNUSED, 10'h3FF);
    send(CMD_SPARE_B, 2'd3, 1'b0, MODE_UNUSED, 10'h3FF);
    repeat (3) send(CMD_STEP_PLAN, 2'd1, 1'b1, MODE_DEFAULT, 10'd0);
    send(CMD_CLEAR_CHANGED, 2'd1, 1'b0, MODE_DEFAULT, 10'd0);
    // A saturated plan step must leave the cleared flag alone.
    send(CMD_STEP_PLAN, 2'd1, 1'b1, MODE_DEFAULT, 10'd0);
    repeat (3) send(CMD_STEP_PLAN, 2'd1, 1'b0, MODE_DEFAULT, 10'd0);
    send(CMD_LOAD_MEASURED, 2'd0, 1'b0, MODE_DEFAULT, 10'd0);
    send(CMD_STEP_TARGET, 2'd0, 1'b0, MODE_DEFAULT, 10'd0);
    send(CMD_SET_MODE, 2'd0, 1'b1, MODE_DEFAULT, 10'd0);
  endtask

  initial begin
    freq_t floors[6];
    sb = new();
    floors = '{AUTO_MIN_RESET, 10'd0, 10'h3FF, 10'd150, freq_t'($urandom_range(0, 1023)),
               10'd41};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      if (phase > 0) begin
        write_auto_floor(floors[phase]);
        floor_settings++;
      end
      run_random(PHASE_ITEMS);
    end
    drain();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d commands (%0d target, %0d max, %0d mode, %0d plan, %0d load steps)",
             sb.checked, sb.cmd_seen[CMD_STEP_TARGET], sb.cmd_seen[CMD_STEP_MAX],
             sb.cmd_seen[CMD_SET_MODE], sb.cmd_seen[CMD_STEP_PLAN],
             sb.cmd_seen[CMD_LOAD_MEASURED]);
    $display("%0d results carried a frequency to apply, over %0d auto floor settings",
             sb.applied, floor_settings);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
